// File: design/assert_macros.svh
// Assertion macros shared by the design files.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check that prop holds at every rising clock edge outside reset.
`define OSTB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that expr is never true at a rising clock edge outside reset.
`define OSTB_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define OSTB_ASSERT(lbl, clk, rst_n, prop, msg)
`define OSTB_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// File: design/ostb_pkg.sv
package ostb_pkg;

  // Bank size and derived widths
  localparam int unsigned NumTimers = 16;
  localparam int unsigned IdxW      = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int unsigned CntW      = $clog2(NumTimers + 1);
  localparam int unsigned TimeW     = 64;
  localparam int unsigned IvlW      = 32;
  localparam int unsigned ScaleW    = 10;
  localparam int unsigned ProdW     = IvlW + ScaleW;
  localparam logic [ScaleW-1:0] MsToUs = ScaleW'(1000);

  // Command codes
  typedef enum logic [1:0] {
    CmdTick   = 2'd0,
    CmdSet    = 2'd1,
    CmdCancel = 2'd2,
    CmdStatus = 2'd3
  } ostb_cmd_e;

  // Input beat
  typedef struct packed {
    logic [1:0]      cmd;
    logic [3:0]      slot_id;
    logic [IvlW-1:0] delay_ms;
  } ostb_in_t;

  // Result beat
  typedef struct packed {
    logic             timer_active;
    logic             timer_expired;
    logic [4:0]       active_count;
    logic             alarm_valid;
    logic [TimeW-1:0] next_alarm_us;
    logic [15:0]      fired_mask;
  } ostb_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic            accept;
    logic            prep;
    logic            apply;
    logic [IdxW-1:0] rd_idx;
    logic            chk_en;
    logic [IdxW-1:0] chk_idx;
    logic            report;
  } ostb_ctl_t;

endpackage

// File: design/ostb_ram.sv
module ostb_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one word, read one word with a registered output
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/ostb_ctrl.sv
`include "assert_macros.svh"

module ostb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output ostb_pkg::ostb_ctl_t ctl_o
);

  typedef enum logic [5:0] {
    SIdle   = 6'b000001,
    SPrep   = 6'b000010,
    SApply  = 6'b000100,
    SScan   = 6'b001000,
    SDrain  = 6'b010000,
    SReport = 6'b100000
  } ostb_state_e;

  localparam logic [ostb_pkg::IdxW-1:0] LastIdx = ostb_pkg::IdxW'(ostb_pkg::NumTimers - 1);

  ostb_state_e                 state_q, state_d;
  logic [ostb_pkg::IdxW-1:0]   scan_q, scan_d;
  logic                        chk_en_q;
  logic [ostb_pkg::IdxW-1:0]   chk_idx_q;

  // Sequence: latch, multiply, apply command, scan every entry, drain, report
  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    unique case (state_q)
      SIdle: begin
        if (start) begin
          state_d = SPrep;
        end
      end
      SPrep: begin
        state_d = SApply;
      end
      SApply: begin
        scan_d  = '0;
        state_d = SScan;
      end
      SScan: begin
        if (scan_q == LastIdx) begin
          state_d = SDrain;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      SDrain: begin
        state_d = SReport;
      end
      SReport: begin
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Hold state and the check slot, registered to line up behind the RAM read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      scan_q    <= '0;
      chk_en_q  <= 1'b0;
      chk_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      scan_q    <= scan_d;
      chk_en_q  <= (state_q == SScan);
      chk_idx_q <= scan_q;
    end
  end

  assign busy = (state_q != SIdle);

  always_comb begin
    ctl_o.accept  = (state_q == SIdle) && start;
    ctl_o.prep    = (state_q == SPrep);
    ctl_o.apply   = (state_q == SApply);
    ctl_o.rd_idx  = scan_q;
    ctl_o.chk_en  = chk_en_q;
    ctl_o.chk_idx = chk_idx_q;
    ctl_o.report  = (state_q == SReport);
  end

  `OSTB_ASSERT(a_accept_to_prep, clk_i, rst_ni, (state_q == SIdle && start) |=> (state_q == SPrep), "accepted beat did not enter prepare")
  `OSTB_ASSERT(a_scan_end, clk_i, rst_ni, (state_q == SScan && scan_q == LastIdx) |=> (state_q == SDrain), "scan overran the last entry")
  `OSTB_ASSERT(a_drain_checks_last, clk_i, rst_ni, (state_q == SDrain) |-> (chk_en_q && chk_idx_q == LastIdx), "last entry not checked in drain")

endmodule

// File: design/ostb_datapath.sv
`include "assert_macros.svh"

module ostb_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ostb_pkg::ostb_ctl_t ctl_i,
  input  ostb_pkg::ostb_in_t  item_i,
  output ostb_pkg::ostb_out_t result_o,
  output logic                done_o
);

  localparam int unsigned N = ostb_pkg::NumTimers;

  // Latched command
  logic [1:0]                 cmd_q;
  logic [3:0]                 id_q;
  logic [ostb_pkg::IvlW-1:0]  ivl_q;
  logic [ostb_pkg::ProdW-1:0] prod_q;

  // Bank state
  logic [ostb_pkg::TimeW-1:0] now_q, now_d;
  logic [N-1:0]               act_q, act_d;
  logic [N-1:0]               exp_q, exp_d;
  logic [ostb_pkg::CntW-1:0]  cnt_q, cnt_d;

  // Scan accumulators
  logic [N-1:0]               fired_q, fired_d;
  logic [ostb_pkg::TimeW-1:0] min_q, min_d;
  logic                       any_q, any_d;

  ostb_pkg::ostb_out_t        result_q;
  logic                       done_q;

  logic                       id_ok;
  logic [ostb_pkg::IdxW-1:0]  k;
  logic                       is_tick;
  logic                       ram_we;
  logic [ostb_pkg::TimeW-1:0] ram_wdata;
  logic [ostb_pkg::TimeW-1:0] ram_rdata;
  logic                       pend;
  logic                       due;

  assign id_ok     = ({1'b0, id_q} < 5'(N));
  assign k         = id_q[ostb_pkg::IdxW-1:0];
  assign is_tick   = (cmd_q == ostb_pkg::CmdTick);
  assign ram_wdata = now_q + ostb_pkg::TimeW'(prod_q);
  assign pend      = act_q[ctl_i.chk_idx] && !exp_q[ctl_i.chk_idx];
  assign due       = (now_q >= ram_rdata);

  ostb_ram #(
    .Width (ostb_pkg::TimeW),
    .Depth (N)
  ) u_deadline_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (k),
    .wdata_i (ram_wdata),
    .raddr_i (ctl_i.rd_idx),
    .rdata_o (ram_rdata)
  );

  // Latch the beat and scale the interval to microseconds
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      cmd_q <= item_i.cmd;
      id_q  <= item_i.slot_id;
      ivl_q <= item_i.delay_ms;
    end
    if (ctl_i.prep) begin
      prod_q <= ostb_pkg::ProdW'(ivl_q) * ostb_pkg::ProdW'(ostb_pkg::MsToUs);
    end
  end

  // Apply the command, then expire due timers on a tick and track the earliest pending deadline
  always_comb begin
    now_d   = now_q;
    act_d   = act_q;
    exp_d   = exp_q;
    cnt_d   = cnt_q;
    fired_d = fired_q;
    min_d   = min_q;
    any_d   = any_q;
    ram_we  = 1'b0;
    if (ctl_i.apply) begin
      fired_d = '0;
      min_d   = '1;
      any_d   = 1'b0;
      case (cmd_q)
        ostb_pkg::CmdTick: begin
          now_d = now_q + 1'b1;
        end
        ostb_pkg::CmdSet: begin
          if (id_ok) begin
            ram_we = 1'b1;
            if (!act_q[k]) begin
              cnt_d = cnt_q + 1'b1;
            end
            act_d[k] = 1'b1;
            exp_d[k] = (ivl_q == '0);
          end
        end
        ostb_pkg::CmdCancel: begin
          if (id_ok && act_q[k]) begin
            act_d[k] = 1'b0;
            exp_d[k] = 1'b0;
            cnt_d    = cnt_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (ctl_i.chk_en && pend) begin
      if (is_tick && due) begin
        act_d[ctl_i.chk_idx]   = 1'b0;
        exp_d[ctl_i.chk_idx]   = 1'b1;
        fired_d[ctl_i.chk_idx] = 1'b1;
        cnt_d                  = cnt_q - 1'b1;
      end else begin
        any_d = 1'b1;
        if (ram_rdata < min_q) begin
          min_d = ram_rdata;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q   <= '0;
      act_q   <= '0;
      exp_q   <= '0;
      cnt_q   <= '0;
      fired_q <= '0;
      min_q   <= '1;
      any_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      now_q   <= now_d;
      act_q   <= act_d;
      exp_q   <= exp_d;
      cnt_q   <= cnt_d;
      fired_q <= fired_d;
      min_q   <= min_d;
      any_q   <= any_d;
      done_q  <= ctl_i.report;
    end
  end

  // Assemble the result beat once the scan has settled
  always_ff @(posedge clk_i) begin
    if (ctl_i.report) begin
      result_q.timer_active  <= id_ok && act_q[k];
      result_q.timer_expired <= id_ok && exp_q[k];
      result_q.active_count  <= 5'(cnt_q);
      result_q.alarm_valid   <= any_q;
      result_q.next_alarm_us <= min_q;
      result_q.fired_mask    <= 16'(fired_q);
    end
  end

  assign result_o = result_q;
  assign done_o   = done_q;

  `OSTB_ASSERT(a_count_matches, clk_i, rst_ni, cnt_q == ostb_pkg::CntW'($countones(act_q)), "bad count")
  `OSTB_ASSERT_NEVER(a_fired_expired, clk_i, rst_ni, (fired_q & ~exp_q) != '0, "fired not expired")
  `OSTB_ASSERT(a_done_pulse, clk_i, rst_ni, done_q |=> !done_q, "result strobe too long")

endmodule

// File: design/one_shot_timer_bank_unit.sv
// Bank of one-shot millisecond timers on a 64-bit microsecond clock.
// Input channel: drive item_i and raise start; the beat is taken at a rising
// edge where start is high and busy is low. Commands: tick one microsecond,
// set a timer, cancel a timer, or read status only.
// Result channel: done_o is high for exactly one cycle and result_o carries
// the beat in that cycle; the receiver must take it then, it cannot stall.
// Each beat runs through prepare (interval times 1000), apply (clock step,
// flag and deadline update), a scan of all timers, a drain state and a
// report state. busy falls as the strobe rises, so the next beat is taken
// at the edge that ends the strobe cycle. The scan reads one deadline per
// cycle through the deadline RAM's single read port.
// Reset clears the clock, all active and expired flags and the active count;
// deadlines are written only by set commands.
module one_shot_timer_bank_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  ostb_pkg::ostb_in_t  item_i,
  output logic                busy,
  output logic                done_o,
  output ostb_pkg::ostb_out_t result_o
);

  ostb_pkg::ostb_ctl_t ctl;

  ostb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctl_o  (ctl)
  );

  ostb_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .item_i   (item_i),
    .result_o (result_o),
    .done_o   (done_o)
  );

endmodule

// File: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomBeats = 1400;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned TailCycles  = 30;

  // Tracks the timer bank and holds the reports it is due to produce
  class timer_bank_tracker;
    logic [ostb_pkg::TimeW-1:0] clock_us;
    logic [ostb_pkg::TimeW-1:0] deadline [ostb_pkg::NumTimers];
    bit                         armed    [ostb_pkg::NumTimers];
    bit                         lapsed   [ostb_pkg::NumTimers];
    logic [4:0]                 armed_total;
    ostb_pkg::ostb_out_t        due_reports [$];
    int unsigned                fails;

    function new();
      clock_us    = '0;
      armed_total = '0;
      fails       = 0;
      for (int i = 0; i < ostb_pkg::NumTimers; i++) begin
        deadline[i] = '0;
        armed[i]    = 1'b0;
        lapsed[i]   = 1'b0;
      end
    endfunction

    function int unsigned outstanding();
      return due_reports.size();
    endfunction

    // Advance the bank by one command and queue the report it yields
    function void note_beat(ostb_pkg::ostb_in_t beat);
      ostb_pkg::ostb_out_t        rep;
      logic [15:0]                fired;
      logic [ostb_pkg::TimeW-1:0] earliest;
      bit                         any_due;
      int unsigned                k;
      fired    = '0;
      earliest = '1;
      any_due  = 1'b0;
      k        = 32'(beat.slot_id);
      case (ostb_pkg::ostb_cmd_e'(beat.cmd))
        ostb_pkg::CmdTick: begin
          clock_us = clock_us + 64'd1;
          for (int i = 0; i < ostb_pkg::NumTimers; i++) begin
            if (armed[i] && !lapsed[i] && clock_us >= deadline[i]) begin
              lapsed[i]   = 1'b1;
              armed[i]    = 1'b0;
              armed_total = armed_total - 5'd1;
              fired[i]    = 1'b1;
            end
          end
        end
        ostb_pkg::CmdSet: begin
          if (armed[k]) armed_total = armed_total - 5'd1;
          deadline[k] = clock_us + ostb_pkg::TimeW'(beat.delay_ms)
                                 * ostb_pkg::TimeW'(ostb_pkg::MsToUs);
          armed[k]    = 1'b1;
          lapsed[k]   = (beat.delay_ms == '0);
          armed_total = armed_total + 5'd1;
        end
        ostb_pkg::CmdCancel: begin
          if (armed[k]) begin
            armed[k]    = 1'b0;
            lapsed[k]   = 1'b0;
            armed_total = armed_total - 5'd1;
          end
        end
        default: ;
      endcase
      // Earliest deadline among timers still pending
      for (int i = 0; i < ostb_pkg::NumTimers; i++) begin
        if (armed[i] && !lapsed[i]) begin
          any_due = 1'b1;
          if (deadline[i] < earliest) earliest = deadline[i];
        end
      end
      rep.timer_active  = armed[k];
      rep.timer_expired = lapsed[k];
      rep.active_count  = armed_total;
      rep.alarm_valid   = any_due;
      rep.next_alarm_us = earliest;
      rep.fired_mask    = fired;
      due_reports.push_back(rep);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        fails++;
      end
    endfunction

    // Match a report from the block against the oldest one due
    function void check_beat(ostb_pkg::ostb_out_t got);
      ostb_pkg::ostb_out_t want;
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, got %h", $time, got);
        fails++;
        return;
      end
      want = due_reports.pop_front();
      compare_field("timer_active",  64'(want.timer_active),  64'(got.timer_active));
      compare_field("timer_expired", 64'(want.timer_expired), 64'(got.timer_expired));
      compare_field("active_count",  64'(want.active_count),  64'(got.active_count));
      compare_field("alarm_valid",   64'(want.alarm_valid),   64'(got.alarm_valid));
      compare_field("next_alarm_us", want.next_alarm_us,      got.next_alarm_us);
      compare_field("fired_mask",    64'(want.fired_mask),    64'(got.fired_mask));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  ostb_pkg::ostb_in_t  item;
  logic                busy;
  logic                done_o;
  ostb_pkg::ostb_out_t result_o;

  timer_bank_tracker board = new();
  bit                idle_en;
  int unsigned       quiet_cycles;

  one_shot_timer_bank_unit i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .item_i   (item),
    .busy     (busy),
    .done_o   (done_o),
    .result_o (result_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Check reports before noting a new command taken on the same edge
  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_beat(result_o);
    if (rst_ni && start && !busy) board.note_beat(item);
  end

  // Stop the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("** one_shot_timer_bank_unit: FAILED **");
        $finish;
      end
    end
  end

  function automatic ostb_pkg::ostb_in_t make_beat(ostb_pkg::ostb_cmd_e cmd, logic [3:0] id,
                                                   logic [31:0] ivl);
    ostb_pkg::ostb_in_t b;
    b.cmd      = cmd;
    b.slot_id  = id;
    b.delay_ms = ivl;
    return b;
  endfunction

  // Offer one command, optionally after a gap or a full drain, and hold it until taken
  task automatic send_item(ostb_pkg::ostb_in_t beat, bit drain);
    int unsigned gap;
    gap = 0;
    if (idle_en && $urandom_range(99) < 14) gap = $urandom_range(1, 30);
    @(negedge clk_i);
    if (drain || gap != 0) begin
      start <= 1'b0;
      @(negedge clk_i);
      if (drain) begin
        while (board.outstanding() != 0) @(negedge clk_i);
      end
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    item  <= beat;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    ostb_pkg::ostb_in_t  beat;
    int unsigned         w;
    logic [31:0]         ivl;
    ostb_pkg::ostb_cmd_e cmd;

    rst_ni  = 1'b0;
    start   = 1'b0;
    item    = '0;
    idle_en = 1'b1;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset state, zero interval, re-arm, cancels, extreme intervals
    send_item(make_beat(ostb_pkg::CmdStatus, 4'd0,  32'd0), 1'b0);
    send_item(make_beat(ostb_pkg::CmdTick,   4'd15, 32'd0), 1'b0);
    send_item(make_beat(ostb_pkg::CmdSet,    4'd0,  32'd0), 1'b0);
    send_item(make_beat(ostb_pkg::CmdTick,   4'd0,  32'd0), 1'b0);
    send_item(make_beat(ostb_pkg::CmdSet,    4'd15, 32'hFFFF_FFFF), 1'b0);
    send_item(make_beat(ostb_pkg::CmdSet,    4'd15, 32'd1), 1'b0);
    send_item(make_beat(ostb_pkg::CmdCancel, 4'd3,  32'd0), 1'b0);
    send_item(make_beat(ostb_pkg::CmdSet,    4'd3,  32'd2), 1'b0);
    send_item(make_beat(ostb_pkg::CmdCancel, 4'd3,  32'd0), 1'b0);
    send_item(make_beat(ostb_pkg::CmdCancel, 4'd3,  32'hFFFF_FFFF), 1'b0);
    send_item(make_beat(ostb_pkg::CmdStatus, 4'd15, 32'd0), 1'b0);
    send_item(make_beat(ostb_pkg::CmdSet,    4'd5,  32'h8000_0000), 1'b0);
    send_item(make_beat(ostb_pkg::CmdSet,    4'd6,  32'h5555_5555), 1'b0);
    send_item(make_beat(ostb_pkg::CmdSet,    4'd7,  32'hAAAA_AAAA), 1'b0);
    send_item(make_beat(ostb_pkg::CmdCancel, 4'd0,  32'd0), 1'b0);
    send_item(make_beat(ostb_pkg::CmdSet,    4'd1,  32'd1), 1'b0);
    send_item(make_beat(ostb_pkg::CmdSet,    4'd2,  32'd1), 1'b0);
    send_item(make_beat(ostb_pkg::CmdStatus, 4'd10, 32'd0), 1'b0);
    send_item(make_beat(ostb_pkg::CmdSet,    4'd8,  32'd0), 1'b0);
    send_item(make_beat(ostb_pkg::CmdCancel, 4'd8,  32'd0), 1'b0);
    send_item(make_beat(ostb_pkg::CmdTick,   4'd1,  32'd0), 1'b0);

    // Random: arm heavily early, then mostly tick so that deadlines come due
    for (int n = 0; n < RandomBeats; n++) begin
      idle_en = !(n >= 400 && n < 800);
      w = $urandom_range(99);
      if (n < 150) begin
        if (w < 45)      cmd = ostb_pkg::CmdTick;
        else if (w < 80) cmd = ostb_pkg::CmdSet;
        else if (w < 90) cmd = ostb_pkg::CmdCancel;
        else             cmd = ostb_pkg::CmdStatus;
      end else begin
        if (w < 88)      cmd = ostb_pkg::CmdTick;
        else if (w < 94) cmd = ostb_pkg::CmdSet;
        else if (w < 97) cmd = ostb_pkg::CmdCancel;
        else             cmd = ostb_pkg::CmdStatus;
      end
      w = $urandom_range(99);
      if (w < 15)      ivl = 32'd0;
      else if (w < 65) ivl = 32'd1;
      else if (w < 75) ivl = 32'd2;
      else             ivl = $urandom;
      beat = make_beat(cmd, 4'($urandom_range(15)), ivl);
      send_item(beat, n == 700);
    end

    // Drop start and drain the remaining reports
    @(negedge clk_i);
    start <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (board.fails == 0) begin
      $display("** one_shot_timer_bank_unit: PASSED **");
    end else begin
      $display("** one_shot_timer_bank_unit: FAILED **");
    end
    $finish;
  end

endmodule
